// File: rtl/bmd_pkg.sv
`default_nettype none

package bmd_pkg;

  // Geometry
  localparam int MAX_SIDE  = 1024;
  localparam int SIDE_W    = 11;
  localparam int POS_W     = $clog2(MAX_SIDE);
  localparam int OUT_POS_W = POS_W - 1;
  localparam int SAMPLE_W  = 16;

  // Line buffer word holds {two rows up, one row up}
  localparam int LINE_W    = 2 * SAMPLE_W;

  // Nine-term window sum and divide by nine as a reciprocal multiply
  localparam int SUM_W      = SAMPLE_W + 4;
  localparam int DIV9_SHIFT = 23;
  localparam logic [SUM_W-1:0] DIV9_RECIP = SUM_W'(((1 << DIV9_SHIFT) + 8) / 9);
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(4);

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  // Position and window flags of one beat
  typedef struct packed {
    logic [POS_W-1:0]     col;
    logic                 row_ge1;
    logic                 row_ge2;
    logic                 col_ge1;
    logic                 col_ge2;
    logic                 emit;
    logic                 drop_top;
    logic                 drop_left;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 frame_last;
  } pos_info_t;

endpackage

`default_nettype wire

// File: rtl/bmd_ram.sv
`default_nettype none

module bmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmd_pos.sv
`default_nettype none

module bmd_pos (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bmd_pkg::SIDE_W-1:0]  cfg_wr_data,
  input  wire logic                        advance,
  output      bmd_pkg::pos_info_t          info
);

  import bmd_pkg::*;

  logic [SIDE_W-1:0] side;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col;
  logic [SIDE_W-1:0] side_m1;
  logic [POS_W-1:0]  last_idx;
  logic              row_last;
  logic              col_last;

  // Last valid index of the clamped side
  always_comb begin
    side_m1 = side - SIDE_W'(1);
    if (side == '0) begin
      last_idx = '0;
    end else if (side > SIDE_W'(MAX_SIDE)) begin
      last_idx = POS_W'(MAX_SIDE - 1);
    end else begin
      last_idx = side_m1[POS_W-1:0];
    end
  end

  assign row_last = (row == last_idx);
  assign col_last = (col == last_idx);

  // Flags for the beat at the current raster position
  always_comb begin
    info.col        = col;
    info.row_ge1    = (row != '0);
    info.row_ge2    = (row[POS_W-1:1] != '0);
    info.col_ge1    = (col != '0);
    info.col_ge2    = (col[POS_W-1:1] != '0);
    info.emit       = (row[0] || row_last) && (col[0] || col_last);
    info.drop_top   = !row[0];
    info.drop_left  = !col[0];
    info.out_row    = row[POS_W-1:1];
    info.out_col    = col[POS_W-1:1];
    info.frame_last = row_last && col_last;
  end

  // Side register and raster counters; a side write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SIDE_RESET;
      row  <= '0;
      col  <= '0;
    end else if (cfg_wr_en) begin
      side <= cfg_wr_data;
      row  <= '0;
      col  <= '0;
    end else if (advance) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmd_calc.sv
`default_nettype none

module bmd_calc (
  input  wire logic                          clk,
  input  wire logic                          advance,
  input  wire bmd_pkg::pos_info_t            info,
  input  wire logic [bmd_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [bmd_pkg::LINE_W-1:0]    line_word,
  output      logic [bmd_pkg::SAMPLE_W-1:0]  mean_value
);

  import bmd_pkg::*;

  // win[0..2]: previous column, win[3..5]: column before that (top to bottom)
  logic [SAMPLE_W-1:0]  win [6];
  logic [SAMPLE_W-1:0]  cur [3];
  logic [SAMPLE_W-1:0]  p0 [3];
  logic [SAMPLE_W-1:0]  p1 [3];
  logic [SUM_W-1:0]     row_sum [3];
  logic [SUM_W-1:0]     sum;
  logic [2*SUM_W-1:0]   prod;

  // Current column from the line buffer, masked above the image
  assign cur[0] = info.row_ge2 ? line_word[LINE_W-1:SAMPLE_W] : '0;
  assign cur[1] = info.row_ge1 ? line_word[SAMPLE_W-1:0] : '0;
  assign cur[2] = sample;

  // Earlier columns, masked left of the image
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = info.col_ge1 ? win[k] : '0;
      p1[k] = info.col_ge2 ? win[3+k] : '0;
      row_sum[k] = SUM_W'(cur[k]) + SUM_W'(p0[k])
                 + (info.drop_left ? '0 : SUM_W'(p1[k]));
    end
  end

  // Sum and round(sum / 9) via reciprocal multiply
  assign sum  = (info.drop_top ? '0 : row_sum[0]) + row_sum[1] + row_sum[2];
  assign prod = (2*SUM_W)'(sum + ROUND_BIAS) * (2*SUM_W)'(DIV9_RECIP);
  assign mean_value = prod[DIV9_SHIFT +: SAMPLE_W];

  // Shift the window by one column per beat
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        win[3+k] <= p0[k];
        win[k]   <= cur[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/box_mean_3x3_stride2_downsampler_top.sv
`default_nettype none

// 3x3 box-mean downsampler, stride two, zero padding. Samples of a square
// image (side set by cfg_wr_data, 1..1024; 0 acts as 1, larger as 1024)
// arrive in raster order, one per beat. For every pixel at an even row and
// column one result beat carries round(window sum / 9) with its position in
// the half-size image; tlast marks the last result of a frame. A side write
// restarts the frame at row 0, column 0 and must be made while idle. The
// block takes one sample per clock; the beat that completes a window
// passes through an input register, and its result leaves through a
// result register. The input waits only while a finished result is held in a
// stalled result register. One RAM holds both earlier rows; it is read at a
// beat's column when the beat is accepted and written back as the beat
// leaves the input register. No clearing pass is needed after reset: rows
// above the image are masked by position.
module box_mean_3x3_stride2_downsampler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,    // side_length
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,   // [15:0] mean_value, [24:16] out_row,
                                           // [33:25] out_col, [39:34] zero
  output      logic        m_axis_tlast    // frame_last
);

  import bmd_pkg::*;

  localparam int OUT_DATA_W = SAMPLE_W + 2 * OUT_POS_W;

  pos_info_t              pos_info;
  pos_info_t              s1_info;
  logic                   s1_valid;
  logic [SAMPLE_W-1:0]    s1_sample;
  logic                   s1_go;
  logic                   in_accept;
  logic [LINE_W-1:0]      line_rd;
  logic [SAMPLE_W-1:0]    mean_next;
  logic [OUT_DATA_W-1:0]  out_data;
  logic                   out_last;

  // Handshake: the stage moves on unless its result meets a full, stalled output
  assign s1_go         = s1_valid && (!s1_info.emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_go;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  bmd_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (in_accept),
    .info        (pos_info)
  );

  // Line buffer: read on accept, rows shift down when the stage moves on
  bmd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_info.col),
    .wr_data ({line_rd[SAMPLE_W-1:0], s1_sample}),
    .rd_en   (in_accept),
    .rd_addr (pos_info.col),
    .rd_data (line_rd)
  );

  bmd_calc u_calc (
    .clk        (clk),
    .advance    (s1_go),
    .info       (s1_info),
    .sample     (s1_sample),
    .line_word  (line_rd),
    .mean_value (mean_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_info   <= pos_info;
      s1_sample <= s_axis_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_go && s1_info.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (s1_go && s1_info.emit) begin
      out_data <= {s1_info.out_col, s1_info.out_row, mean_next};
      out_last <= s1_info.frame_last;
    end
  end

  assign m_axis_tdata = {(40 - OUT_DATA_W)'(0), out_data};
  assign m_axis_tlast = out_last;

`ifndef SYNTH
  // Input stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // An accepted beat always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted beat lost");

  // A result moving on shows up on the output
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_info.emit |=> m_axis_tvalid)
    else $error("result not presented");

  // The frame's last result sits on the diagonal corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> out_data[OUT_DATA_W-1 -: OUT_POS_W] ==
      out_data[SAMPLE_W +: OUT_POS_W])
    else $error("frame end off the corner");
`endif

endmodule

`default_nettype wire

// File: test/box_mean_3x3_stride2_downsampler_top_tb.sv
`timescale 1ns / 100ps

module box_mean_3x3_stride2_downsampler_top_tb;
  import bmd_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // covers the input register and the result register
  localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side and no side write
  localparam int RANDOM_ITEMS  = 360;
  localparam int PLAN_ROWS     = 29;

  // One output beat, field by field
  typedef struct packed {
    logic [SAMPLE_W-1:0]  mean;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } box_res_t;

  // Directed row: either a side write or a sample with an optional known result
  typedef struct packed {
    logic           is_side;
    logic [15:0]    value;
    logic           typed;
    box_res_t       want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [SIDE_W-1:0]   cfg_wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;
  logic                m_axis_tlast;

  // Predictor state
  logic [SIDE_W-1:0]   side_q;
  logic [SAMPLE_W-1:0] older_line [MAX_SIDE];
  logic [SAMPLE_W-1:0] newer_line [MAX_SIDE];
  logic [SAMPLE_W-1:0] win_cols [6];
  int unsigned         row_q;
  int unsigned         col_q;

  box_res_t            pending_means [$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  int                  sink_pause = 0;
  bit                  src_free = 1'b0;
  bit                  sink_free = 1'b0;

  box_mean_3x3_stride2_downsampler_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed plan: extremes, side clamping, frame wrap, padding on all edges
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'h0000, 1'b0, '0},
    '{1'b1, 16'd1,    1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd7282, 9'd0, 9'd0, 1'b1}},
    '{1'b1, 16'd0,    1'b0, '0},
    '{1'b0, 16'h0000, 1'b1, '{16'd0, 9'd0, 9'd0, 1'b1}},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd7282, 9'd0, 9'd0, 1'b1}},
    '{1'b1, 16'd2,    1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd29127, 9'd0, 9'd0, 1'b1}},
    '{1'b1, 16'd4,    1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd29127, 9'd0, 9'd0, 1'b0}},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd43690, 9'd0, 9'd1, 1'b0}},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd43690, 9'd1, 9'd0, 1'b0}},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b1, '{16'd65535, 9'd1, 9'd1, 1'b1}}
  };

  // Window mean for one sample; advances the line stores and raster position
  function automatic bit next_box_mean(input logic [SAMPLE_W-1:0] s, output box_res_t res);
    int unsigned   n, r, c, crow, ccol, sum, mean, k, k0;
    logic [SAMPLE_W-1:0] cur [3];
    logic [SAMPLE_W-1:0] p0 [3];
    logic [SAMPLE_W-1:0] p1 [3];
    bit            have_row, have_col, drop_top, drop_left;
    n = (side_q == 0) ? 1 : ((side_q > MAX_SIDE) ? MAX_SIDE : side_q);
    r = (row_q >= n) ? 0 : row_q;
    c = (col_q >= n) ? 0 : col_q;
    res = '0;
    crow = 0;
    ccol = 0;
    sum = 0;
    have_row = 1'b0;
    have_col = 1'b0;
    drop_top = 1'b0;
    drop_left = 1'b0;

    // column from the line stores, rows above the image read as zero
    cur[0] = (r >= 2) ? older_line[c[POS_W-1:0]] : '0;
    cur[1] = (r >= 1) ? newer_line[c[POS_W-1:0]] : '0;
    cur[2] = s;
    older_line[c[POS_W-1:0]] = newer_line[c[POS_W-1:0]];
    newer_line[c[POS_W-1:0]] = s;
    for (k = 0; k < 3; k++) begin
      p0[k] = (c >= 1) ? win_cols[k] : '0;
      p1[k] = (c >= 2) ? win_cols[3 + k] : '0;
    end

    if ((r % 2) == 1) begin
      have_row = 1'b1;
      crow = r - 1;
    end else if (r == n - 1) begin
      have_row = 1'b1;
      crow = r;
      drop_top = 1'b1;
    end
    if ((c % 2) == 1) begin
      have_col = 1'b1;
      ccol = c - 1;
    end else if (c == n - 1) begin
      have_col = 1'b1;
      ccol = c;
      drop_left = 1'b1;
    end

    if (have_row && have_col) begin
      k0 = drop_top ? 1 : 0;
      for (k = k0; k < 3; k++) begin
        sum += cur[k] + p0[k];
        if (!drop_left) sum += p1[k];
      end
      mean = (sum + 4) / 9;
      if (mean > 65535) mean = 65535;
      res.mean = mean[SAMPLE_W-1:0];
      res.row  = crow[OUT_POS_W:1];
      res.col  = ccol[OUT_POS_W:1];
      res.last = (r == n - 1) && (c == n - 1);
    end

    for (k = 0; k < 3; k++) begin
      win_cols[3 + k] = p0[k];
      win_cols[k] = cur[k];
    end

    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    row_q = r;
    col_q = c;
    return have_row && have_col;
  endfunction

  // Wait out every pending result and the output pipeline
  task automatic wait_drained();
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Side write, made only while the block is idle
  task automatic write_side(input logic [SIDE_W-1:0] side);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= side;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_q = side;
    row_q  = 0;
    col_q  = 0;
  endtask

  // One input beat; valid is only lowered for a gap before the beat
  task automatic drive_sample(input logic [15:0] value, input bit typed, input box_res_t want);
    int       gap;
    box_res_t got;
    bit       hit;
    gap = src_free ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    hit = next_box_mean(value, got);
    if (typed) pending_means.push_back(want);
    else if (hit) pending_means.push_back(got);
  endtask

  // Compare one output beat with the oldest expectation
  task automatic check_mean_beat(input logic [39:0] data, input logic last);
    box_res_t exp_res;
    if (pending_means.size() == 0) begin
      $display("%0t: result beat with nothing expected: mean %0d row %0d col %0d last %0b",
               $time, data[15:0], data[24:16], data[33:25], last);
      errors++;
    end else begin
      exp_res = pending_means.pop_front();
      if (data[15:0] !== exp_res.mean) begin
        $display("%0t: mean_value expected %0d actual %0d", $time, exp_res.mean, data[15:0]);
        errors++;
      end
      if (data[24:16] !== exp_res.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, data[24:16]);
        errors++;
      end
      if (data[33:25] !== exp_res.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, data[33:25]);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, exp_res.last, last);
        errors++;
      end
    end
  endtask

  // Result side: random stall after each beat unless sink_free is set
  always @(posedge clk) begin : sink_side
    int pause;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_mean_beat(m_axis_tdata, m_axis_tlast);
      pause = sink_free ? 0 : $urandom_range(0, 14);
      m_axis_tready <= (pause == 0);
      if (pause != 0) sink_pause <= pause;
    end else if (sink_pause != 0) begin
      sink_pause <= sink_pause - 1;
      m_axis_tready <= (sink_pause == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no beat and no write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          sent, count, n, mode;
    logic [15:0] value;
    logic [SIDE_W-1:0] side;

    side_q = SIDE_RESET;
    row_q = 0;
    col_q = 0;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, first rows run at the reset side
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_side) write_side(directed_plan[i].value[SIDE_W-1:0]);
      else drive_sample(directed_plan[i].value, directed_plan[i].typed, directed_plan[i].want);
    end

    // largest side with a source that never pauses
    write_side(11'd1024);
    src_free  = 1'b1;
    sink_free = 1'b0;
    repeat (40) drive_sample(16'($urandom), 1'b0, '0);

    // side above range acts as the largest side
    write_side(11'd2047);
    src_free = 1'b0;
    repeat (30) drive_sample(16'($urandom), 1'b0, '0);

    // random phases, mostly small sides, often mid-frame restarts
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) side = SIDE_W'($urandom_range(13, 40));
      else side = SIDE_W'($urandom_range(0, 12));
      n = (side == 0) ? 1 : int'(side);
      count = $urandom_range(1, 2 * n * n + 3);
      if (count > 200) count = 200;
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      mode = $urandom_range(0, 4);
      write_side(side);
      src_free  = ($urandom_range(0, 3) == 0);
      sink_free = ($urandom_range(0, 3) == 0);
      repeat (count) begin
        case ($urandom_range(0, 7))
          0:       value = 16'h0000;
          1:       value = 16'hFFFF;
          default: value = 16'($urandom);
        endcase
        if (mode == 0) value = 16'hFFFF;
        drive_sample(value, 1'b0, '0);
      end
      sent += count;
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
